FILE: hw/rtl/hrt_pkg.sv
package hrt_pkg;

    typedef enum logic [7:0] {
        PH_METHOD    = 8'b0000_0001,
        PH_RESOURCE  = 8'b0000_0010,
        PH_VERSION   = 8'b0000_0100,
        PH_LINESTART = 8'b0000_1000,
        PH_NAME      = 8'b0001_0000,
        PH_SPACES    = 8'b0010_0000,
        PH_VALUE     = 8'b0100_0000,
        PH_BODY      = 8'b1000_0000
    } phase_t;

    typedef enum logic [2:0] {
        TAG_METHOD   = 3'd0,
        TAG_RESOURCE = 3'd1,
        TAG_VERSION  = 3'd2,
        TAG_NAME     = 3'd3,
        TAG_VALUE    = 3'd4,
        TAG_BODY     = 3'd5,
        TAG_SKIP     = 3'd6
    } tag_t;

    typedef enum logic [1:0] {
        M_UNDECIDED = 2'd0,
        M_GET       = 2'd1,
        M_POST      = 2'd2,
        M_UNSUP     = 2'd3
    } method_t;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [7:0] HEADER_MAX = 8'hFF;

    // One queue entry holds all results caused by one input byte. When pair is set,
    // a CR with tag first_tag goes out ahead of the entry's own byte.
    typedef struct packed {
        logic [7:0] data;
        tag_t       tag;
        logic       pair;
        tag_t       first_tag;
        method_t    method;
        logic [7:0] count;
        logic       last;
        logic       trunc;
    } entry_t;

    function automatic logic [7:0] get_char(input logic [1:0] pos);
        logic [7:0] c;
        unique case (pos)
            2'd0: c = 8'h47;
            2'd1: c = 8'h45;
            2'd2: c = 8'h54;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] post_char(input logic [1:0] pos);
        logic [7:0] c;
        unique case (pos)
            2'd0: c = 8'h50;
            2'd1: c = 8'h4F;
            2'd2: c = 8'h53;
            default: c = 8'h54;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/hrt_front.sv
module hrt_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    output logic            push_valid,
    input  logic            push_ready,
    output hrt_pkg::entry_t push_data
);

    hrt_pkg::phase_t  phase_reg, phase_next;
    logic [2:0]       pos_reg, pos_next;
    logic             get_reg, get_next;
    logic             post_reg, post_next;
    hrt_pkg::method_t method_reg, method_next;
    logic             skip_reg, skip_next;
    logic             held_reg, held_next;
    logic [7:0]       count_reg, count_next;

    logic             accept;
    logic             emit;
    logic             pair;
    hrt_pkg::tag_t    tag;
    hrt_pkg::tag_t    first_tag;
    hrt_pkg::method_t method_out;
    logic [7:0]       count_step;

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;
    assign count_step = (count_reg != hrt_pkg::HEADER_MAX) ? count_reg + 8'd1 : count_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        get_next    = get_reg;
        post_next   = post_reg;
        method_next = method_reg;
        skip_next   = skip_reg;
        held_next   = held_reg;
        count_next  = count_reg;
        emit        = 1'b1;
        pair        = 1'b0;
        tag         = hrt_pkg::TAG_SKIP;
        first_tag   = hrt_pkg::TAG_SKIP;

        if (skip_reg)
        begin
            skip_next = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                hrt_pkg::PH_METHOD:
                begin
                    if (data_byte == hrt_pkg::CH_SP)
                    begin
                        if (method_reg == hrt_pkg::M_UNDECIDED)
                            method_next = hrt_pkg::M_UNSUP;
                        phase_next = hrt_pkg::PH_RESOURCE;
                    end
                    else
                    begin
                        tag = hrt_pkg::TAG_METHOD;
                        if (pos_reg < 3'd3 && data_byte != hrt_pkg::get_char(pos_reg[1:0]))
                            get_next = 1'b0;
                        if (pos_reg < 3'd4 && data_byte != hrt_pkg::post_char(pos_reg[1:0]))
                            post_next = 1'b0;
                        if (pos_reg < 3'd4)
                            pos_next = pos_reg + 3'd1;
                        if (method_reg == hrt_pkg::M_UNDECIDED)
                        begin
                            priority if (get_next && pos_next == 3'd3)
                                method_next = hrt_pkg::M_GET;
                            else if (post_next && pos_next == 3'd4)
                                method_next = hrt_pkg::M_POST;
                            else if (!get_next && !post_next)
                                method_next = hrt_pkg::M_UNSUP;
                            else
                                method_next = method_reg;
                        end
                    end
                end
                hrt_pkg::PH_RESOURCE:
                begin
                    if (data_byte == hrt_pkg::CH_SP)
                        phase_next = hrt_pkg::PH_VERSION;
                    else
                        tag = hrt_pkg::TAG_RESOURCE;
                end
                hrt_pkg::PH_VERSION:
                begin
                    if (data_byte == hrt_pkg::CH_CR || data_byte == hrt_pkg::CH_LF)
                    begin
                        skip_next  = 1'b1;
                        phase_next = hrt_pkg::PH_LINESTART;
                    end
                    else
                        tag = hrt_pkg::TAG_VERSION;
                end
                hrt_pkg::PH_LINESTART:
                begin
                    if (held_reg)
                    begin
                        held_next = 1'b0;
                        pair      = 1'b1;
                        if (data_byte == hrt_pkg::CH_LF)
                            phase_next = hrt_pkg::PH_BODY;
                        else
                        begin
                            count_next = count_step;
                            first_tag  = hrt_pkg::TAG_NAME;
                            if (data_byte == hrt_pkg::CH_COLON)
                                phase_next = hrt_pkg::PH_SPACES;
                            else
                            begin
                                phase_next = hrt_pkg::PH_NAME;
                                tag        = hrt_pkg::TAG_NAME;
                            end
                        end
                    end
                    else if (data_byte == hrt_pkg::CH_CR)
                    begin
                        // A line-start CR waits for the next byte unless the buffer ends here.
                        if (!last_byte)
                        begin
                            held_next = 1'b1;
                            emit      = 1'b0;
                        end
                    end
                    else
                    begin
                        count_next = count_step;
                        if (data_byte == hrt_pkg::CH_COLON)
                            phase_next = hrt_pkg::PH_SPACES;
                        else
                        begin
                            phase_next = hrt_pkg::PH_NAME;
                            tag        = hrt_pkg::TAG_NAME;
                        end
                    end
                end
                hrt_pkg::PH_NAME:
                begin
                    if (data_byte == hrt_pkg::CH_COLON)
                        phase_next = hrt_pkg::PH_SPACES;
                    else
                        tag = hrt_pkg::TAG_NAME;
                end
                hrt_pkg::PH_SPACES, hrt_pkg::PH_VALUE:
                begin
                    if (phase_reg == hrt_pkg::PH_SPACES && data_byte == hrt_pkg::CH_SP)
                        tag = hrt_pkg::TAG_SKIP;
                    else if (data_byte == hrt_pkg::CH_CR || data_byte == hrt_pkg::CH_LF)
                    begin
                        skip_next  = 1'b1;
                        phase_next = hrt_pkg::PH_LINESTART;
                    end
                    else
                    begin
                        phase_next = hrt_pkg::PH_VALUE;
                        tag        = hrt_pkg::TAG_VALUE;
                    end
                end
                hrt_pkg::PH_BODY:
                begin
                    tag = hrt_pkg::TAG_BODY;
                end
                default:
                begin
                    tag = hrt_pkg::TAG_BODY;
                end
            endcase
        end

        if (last_byte && method_next == hrt_pkg::M_UNDECIDED)
            method_out = hrt_pkg::M_UNSUP;
        else
            method_out = method_next;
    end

    assign push_valid          = in_valid && emit;
    assign push_data.data      = data_byte;
    assign push_data.tag       = tag;
    assign push_data.pair      = pair;
    assign push_data.first_tag = first_tag;
    assign push_data.method    = method_out;
    assign push_data.count     = count_next;
    assign push_data.last      = last_byte;
    assign push_data.trunc     = (phase_next != hrt_pkg::PH_BODY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= hrt_pkg::PH_METHOD;
            pos_reg    <= 3'd0;
            get_reg    <= 1'b1;
            post_reg   <= 1'b1;
            method_reg <= hrt_pkg::M_UNDECIDED;
            skip_reg   <= 1'b0;
            held_reg   <= 1'b0;
            count_reg  <= 8'd0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                phase_reg  <= hrt_pkg::PH_METHOD;
                pos_reg    <= 3'd0;
                get_reg    <= 1'b1;
                post_reg   <= 1'b1;
                method_reg <= hrt_pkg::M_UNDECIDED;
                skip_reg   <= 1'b0;
                held_reg   <= 1'b0;
                count_reg  <= 8'd0;
            end
            else
            begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                get_reg    <= get_next;
                post_reg   <= post_next;
                method_reg <= method_next;
                skip_reg   <= skip_next;
                held_reg   <= held_next;
                count_reg  <= count_next;
            end
        end
    end

endmodule

FILE: hw/rtl/hrt_queue.sv
module hrt_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  hrt_pkg::entry_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output hrt_pkg::entry_t pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hrt_pkg::entry_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_next    = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        rd_next    = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_next;
            if (pop)
                rd_reg <= rd_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(DEPTH))
        else $error("queue fill level above depth");
`endif

endmodule

FILE: hw/rtl/hrt_back.sv
module hrt_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    output logic            head_pop,
    input  hrt_pkg::entry_t head,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output hrt_pkg::tag_t   field_tag,
    output hrt_pkg::method_t method_code,
    output logic [7:0]      header_count,
    output logic            request_end,
    output logic            truncated,
    output logic            last_of_run
);

    logic half_reg, half_next;
    logic first;

    // The held CR of a pair goes out first; the entry leaves the queue with its own byte.
    assign first        = head.pair && !half_reg;
    assign out_valid    = head_valid;
    assign out_byte     = first ? hrt_pkg::CH_CR : head.data;
    assign field_tag    = first ? head.first_tag : head.tag;
    assign method_code  = head.method;
    assign header_count = head.count;
    assign last_of_run  = !first;
    assign request_end  = head.last && !first;
    assign truncated    = head.last && head.trunc && !first;
    assign head_pop     = head_valid && out_ready && !first;

    always_comb
    begin
        half_next = half_reg;
        if (head_valid && out_ready)
            half_next = first;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_reg <= 1'b0;
        else
            half_reg <= half_next;
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && first |=> out_valid && half_reg)
        else $error("second result of a pair did not follow");
`endif

endmodule

FILE: hw/rtl/http_request_tokenizer.sv
// HTTP request tokenizer: takes one raw request byte per transfer on the slave side and
// gives one tagged result per transfer on the master side. A byte is accepted every cycle
// while the result queue (DEPTH entries) has room; its results enter the queue in the same
// cycle and can leave on the next. A header line-start CR that is not the request's last byte
// yields no result until the next byte arrives, and that byte then yields two results, which
// leave in turn through the single output port; input runs at one byte per cycle while the
// output keeps up; pairs cost extra output slots. tlast marks the last result of one input byte.
module http_request_tokenizer #(
    parameter int DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [9:8] method_code, [17:10] header_count, zero
    output logic [4:0]  m_tuser,   // [2:0] field_tag, [3] request_end, [4] truncated
    output logic        m_tlast    // last_of_run
);

    hrt_pkg::entry_t  push_data;
    hrt_pkg::entry_t  head;
    logic             push_valid;
    logic             push_ready;
    logic             head_valid;
    logic             head_pop;
    logic [7:0]       out_byte;
    hrt_pkg::tag_t    field_tag;
    hrt_pkg::method_t method_code;
    logic [7:0]       header_count;
    logic             request_end;
    logic             truncated;

    hrt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .data_byte  (s_tdata),
        .last_byte  (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    hrt_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (head_valid),
        .pop_ready  (head_pop),
        .pop_data   (head)
    );

    hrt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_pop     (head_pop),
        .head         (head),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_byte     (out_byte),
        .field_tag    (field_tag),
        .method_code  (method_code),
        .header_count (header_count),
        .request_end  (request_end),
        .truncated    (truncated),
        .last_of_run  (m_tlast)
    );

    assign m_tdata = {6'd0, header_count, method_code, out_byte};
    assign m_tuser = {truncated, request_end, field_tag};

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[4] |-> m_tuser[3])
        else $error("truncated without request end");
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[3] |-> m_tlast)
        else $error("request end on a result that is not last of its run");
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[7:0] == hrt_pkg::CH_CR)
        else $error("first result of a pair is not the held CR");
`endif

endmodule

FILE: verif/http_tokenizer_checker.sv
module http_tokenizer_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [7:0] out_byte, [9:8] method_code, [17:10] header_count, zero
    input  logic [4:0]  m_tuser,   // [2:0] field_tag, [3] request_end, [4] truncated
    input  logic        m_tlast,   // last_of_run
    output int          error_count,
    output int          pending,
    output int          result_count
);

    localparam logic [23:0] GET_WORD  = "GET";
    localparam logic [31:0] POST_WORD = "POST";

    typedef struct {
        logic [7:0]       data;
        hrt_pkg::tag_t    tag;
        hrt_pkg::method_t method;
        logic [7:0]       count;
        logic             req_end;
        logic             trunc;
        logic             run_last;
    } token_t;

    // Shadow copy of the tokenizer state.
    hrt_pkg::phase_t  ph;
    logic [2:0]       mpos;
    logic             get_ok;
    logic             post_ok;
    hrt_pkg::method_t mcode;
    logic             skip_next;
    logic             cr_held;
    logic [7:0]       hdr_cnt;

    token_t expected_tokens[$];
    token_t head;

    function automatic void clear_parser();
        ph        = hrt_pkg::PH_METHOD;
        mpos      = 3'd0;
        get_ok    = 1'b1;
        post_ok   = 1'b1;
        mcode     = hrt_pkg::M_UNDECIDED;
        skip_next = 1'b0;
        cr_held   = 1'b0;
        hdr_cnt   = 8'd0;
    endfunction

    function automatic void open_header();
        if (hdr_cnt != 8'hFF)
            hdr_cnt++;
        ph = hrt_pkg::PH_NAME;
    endfunction

    function automatic hrt_pkg::tag_t name_tag(input logic [7:0] b);
        if (b == hrt_pkg::CH_COLON)
        begin
            ph = hrt_pkg::PH_SPACES;
            return hrt_pkg::TAG_SKIP;
        end
        return hrt_pkg::TAG_NAME;
    endfunction

    function automatic hrt_pkg::tag_t value_tag(input logic [7:0] b);
        if (b == hrt_pkg::CH_CR || b == hrt_pkg::CH_LF)
        begin
            skip_next = 1'b1;
            ph        = hrt_pkg::PH_LINESTART;
            return hrt_pkg::TAG_SKIP;
        end
        ph = hrt_pkg::PH_VALUE;
        return hrt_pkg::TAG_VALUE;
    endfunction

    // Classifies one accepted byte and queues the zero, one or two results it causes.
    function automatic void tokenize(input logic [7:0] b, input logic last);
        logic [7:0]    outb [0:1];
        hrt_pkg::tag_t tg [0:1];
        int            n;
        token_t        t;
        n = 0;
        if (skip_next)
        begin
            skip_next = 1'b0;
            outb[0]   = b;
            tg[0]     = hrt_pkg::TAG_SKIP;
            n         = 1;
        end
        else
        begin
            case (ph)
                hrt_pkg::PH_METHOD:
                begin
                    outb[0] = b;
                    n       = 1;
                    if (b == hrt_pkg::CH_SP)
                    begin
                        if (mcode == hrt_pkg::M_UNDECIDED)
                            mcode = hrt_pkg::M_UNSUP;
                        ph    = hrt_pkg::PH_RESOURCE;
                        tg[0] = hrt_pkg::TAG_SKIP;
                    end
                    else
                    begin
                        if (mpos < 3'd3 && b != GET_WORD[23 - 8 * int'(mpos) -: 8])
                            get_ok = 1'b0;
                        if (mpos < 3'd4 && b != POST_WORD[31 - 8 * int'(mpos) -: 8])
                            post_ok = 1'b0;
                        if (mpos < 3'd4)
                            mpos++;
                        if (mcode == hrt_pkg::M_UNDECIDED)
                        begin
                            if (get_ok && mpos == 3'd3)
                                mcode = hrt_pkg::M_GET;
                            else if (post_ok && mpos == 3'd4)
                                mcode = hrt_pkg::M_POST;
                            else if (!get_ok && !post_ok)
                                mcode = hrt_pkg::M_UNSUP;
                        end
                        tg[0] = hrt_pkg::TAG_METHOD;
                    end
                end
                hrt_pkg::PH_RESOURCE:
                begin
                    outb[0] = b;
                    n       = 1;
                    if (b == hrt_pkg::CH_SP)
                    begin
                        tg[0] = hrt_pkg::TAG_SKIP;
                        ph    = hrt_pkg::PH_VERSION;
                    end
                    else
                        tg[0] = hrt_pkg::TAG_RESOURCE;
                end
                hrt_pkg::PH_VERSION:
                begin
                    outb[0] = b;
                    n       = 1;
                    if (b == hrt_pkg::CH_CR || b == hrt_pkg::CH_LF)
                    begin
                        tg[0]     = hrt_pkg::TAG_SKIP;
                        skip_next = 1'b1;
                        ph        = hrt_pkg::PH_LINESTART;
                    end
                    else
                        tg[0] = hrt_pkg::TAG_VERSION;
                end
                hrt_pkg::PH_LINESTART:
                begin
                    if (cr_held)
                    begin
                        cr_held = 1'b0;
                        outb[0] = hrt_pkg::CH_CR;
                        outb[1] = b;
                        n       = 2;
                        if (b == hrt_pkg::CH_LF)
                        begin
                            tg[0] = hrt_pkg::TAG_SKIP;
                            tg[1] = hrt_pkg::TAG_SKIP;
                            ph    = hrt_pkg::PH_BODY;
                        end
                        else
                        begin
                            open_header();
                            tg[0] = hrt_pkg::TAG_NAME;
                            tg[1] = name_tag(b);
                        end
                    end
                    else if (b == hrt_pkg::CH_CR)
                    begin
                        // A CR that is also the final byte cannot wait for a partner.
                        if (last)
                        begin
                            outb[0] = b;
                            tg[0]   = hrt_pkg::TAG_SKIP;
                            n       = 1;
                        end
                        else
                            cr_held = 1'b1;
                    end
                    else
                    begin
                        open_header();
                        outb[0] = b;
                        tg[0]   = name_tag(b);
                        n       = 1;
                    end
                end
                hrt_pkg::PH_NAME:
                begin
                    outb[0] = b;
                    tg[0]   = name_tag(b);
                    n       = 1;
                end
                hrt_pkg::PH_SPACES:
                begin
                    outb[0] = b;
                    n       = 1;
                    if (b == hrt_pkg::CH_SP)
                        tg[0] = hrt_pkg::TAG_SKIP;
                    else
                        tg[0] = value_tag(b);
                end
                hrt_pkg::PH_VALUE:
                begin
                    outb[0] = b;
                    tg[0]   = value_tag(b);
                    n       = 1;
                end
                default:
                begin
                    outb[0] = b;
                    tg[0]   = hrt_pkg::TAG_BODY;
                    n       = 1;
                end
            endcase
        end

        if (last && mcode == hrt_pkg::M_UNDECIDED)
            mcode = hrt_pkg::M_UNSUP;

        for (int k = 0; k < n; k++)
        begin
            t.data     = outb[k];
            t.tag      = tg[k];
            t.method   = mcode;
            t.count    = hdr_cnt;
            t.run_last = (k == n - 1);
            t.req_end  = last && t.run_last;
            t.trunc    = last && t.run_last && (ph != hrt_pkg::PH_BODY);
            expected_tokens.push_back(t);
        end

        if (last)
            clear_parser();
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp,
                                        input logic [31:0] act);
        if (act !== exp)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
            error_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            expected_tokens.delete();
            pending      = 0;
            error_count  = 0;
            result_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                tokenize(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $error("result with no expectation waiting: out_byte 0x%02h", m_tdata[7:0]);
                    error_count++;
                end
                else
                begin
                    head = expected_tokens.pop_front();
                    check_field("out_byte", 32'(head.data), 32'(m_tdata[7:0]));
                    check_field("method_code", 32'(head.method), 32'(m_tdata[9:8]));
                    check_field("header_count", 32'(head.count), 32'(m_tdata[17:10]));
                    check_field("tdata_pad", 32'(0), 32'(m_tdata[23:18]));
                    check_field("field_tag", 32'(head.tag), 32'(m_tuser[2:0]));
                    check_field("request_end", 32'(head.req_end), 32'(m_tuser[3]));
                    check_field("truncated", 32'(head.trunc), 32'(m_tuser[4]));
                    check_field("last_of_run", 32'(head.run_last), 32'(m_tlast));
                end
                result_count++;
            end
            pending = expected_tokens.size();
        end
    end

endmodule

FILE: verif/tb_top.sv
module tb_top;

    // The header count overflow request alone is close to 800 bytes of this total.
    localparam int ITEMS_TARGET   = 1050;
    localparam int HOLD_AT        = 150;
    localparam int HOLD_CYCLES    = 200;
    localparam int QUIET_FROM     = 600;
    localparam int QUIET_TO       = 700;
    localparam int OVERFLOW_AT    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;

    int error_count;
    int pending;
    int result_count;
    int items_sent = 0;
    int requests_sent = 0;
    int idle_cycles = 0;

    logic [7:0] req_bytes[$];

    always #10 clk = ~clk;

    http_request_tokenizer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    http_tokenizer_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .error_count  (error_count),
        .pending      (pending),
        .result_count (result_count)
    );

    // Mostly short gaps, a few long ones, and none at all inside the quiet window.
    function automatic int idle_len();
        int r;
        if (items_sent >= QUIET_FROM && items_sent < QUIET_TO)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_byte_except(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == a || c == b)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic void add_text(input int len, input logic [7:0] a, input logic [7:0] b);
        repeat (len)
            req_bytes.push_back(rand_byte_except(a, b));
    endfunction

    function automatic void add_any(input int len);
        repeat (len)
            req_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            req_bytes.push_back(s[i]);
    endfunction

    // Mostly CR LF; otherwise a lone CR or LF followed by an arbitrary byte that gets skipped.
    function automatic void add_line_end();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            req_bytes.push_back(hrt_pkg::CH_CR);
            req_bytes.push_back(hrt_pkg::CH_LF);
        end
        else
        begin
            req_bytes.push_back((r < 85) ? hrt_pkg::CH_LF : hrt_pkg::CH_CR);
            add_any(1);
        end
    endfunction

    task automatic send_request();
        int gap;
        for (int k = 0; k < req_bytes.size(); k++)
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= req_bytes[k];
            s_tlast  <= (k == req_bytes.size() - 1);
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            items_sent++;
            gap = idle_len();
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_bytes.delete();
        requests_sent++;
    endtask

    // Output side: random bursts and stalls, plus one long hold-off that backs up the input.
    initial
    begin
        int gap;
        bit hold_done;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!hold_done && items_sent >= HOLD_AT)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            gap = idle_len();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired with %0d results outstanding", pending);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        int  sel;
        int  cut;
        bit  overflow_done;
        overflow_done = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // The buffer ends while the method is still undecided.
        add_str("G");
        send_request();

        // A space cuts the method short, the resource is empty, a bare LF ends the version,
        // and a CR at line start is the final byte.
        add_str("POS  ");
        req_bytes.push_back(hrt_pkg::CH_LF);
        req_bytes.push_back(8'h00);
        req_bytes.push_back(hrt_pkg::CH_CR);
        send_request();

        // GET with a bare LF header name, a held CR that opens a name, a colon at line
        // start, the blank line and one body byte.
        add_str("GET a b");
        req_bytes.push_back(hrt_pkg::CH_CR);
        req_bytes.push_back(hrt_pkg::CH_LF);
        req_bytes.push_back(hrt_pkg::CH_LF);
        add_str(":");
        req_bytes.push_back(hrt_pkg::CH_LF);
        req_bytes.push_back(8'h00);
        req_bytes.push_back(hrt_pkg::CH_CR);
        add_str("A: v");
        req_bytes.push_back(hrt_pkg::CH_LF);
        req_bytes.push_back(8'h00);
        add_str(":");
        req_bytes.push_back(hrt_pkg::CH_CR);
        req_bytes.push_back(hrt_pkg::CH_LF);
        req_bytes.push_back(hrt_pkg::CH_CR);
        req_bytes.push_back(hrt_pkg::CH_LF);
        req_bytes.push_back(8'hFF);
        send_request();

        while (items_sent < ITEMS_TARGET)
        begin
            sel = $urandom_range(0, 99);
            if (!overflow_done && items_sent >= OVERFLOW_AT)
            begin
                // More minimal headers than the count can hold, so it saturates at its ceiling.
                overflow_done = 1'b1;
                add_str("GET / v");
                req_bytes.push_back(hrt_pkg::CH_CR);
                req_bytes.push_back(hrt_pkg::CH_LF);
                repeat (258)
                begin
                    add_str(":");
                    req_bytes.push_back(hrt_pkg::CH_CR);
                    req_bytes.push_back(hrt_pkg::CH_LF);
                end
                req_bytes.push_back(hrt_pkg::CH_CR);
                req_bytes.push_back(hrt_pkg::CH_LF);
                add_str("ok");
            end
            else if (sel < 8)
                add_any($urandom_range(1, 12));
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: add_str("GET");
                    4, 5, 6, 7: add_str("POST");
                    8:
                    begin
                        case ($urandom_range(0, 4))
                            0: add_str("GE");
                            1: add_str("POS");
                            2: add_str("GETS");
                            3: add_str("POSTX");
                            default: add_str("PUT");
                        endcase
                    end
                    default: add_text($urandom_range(1, 6), hrt_pkg::CH_SP, hrt_pkg::CH_SP);
                endcase
                add_str(" ");
                add_text($urandom_range(0, 8), hrt_pkg::CH_SP, hrt_pkg::CH_SP);
                add_str(" ");
                add_text($urandom_range(0, 8), hrt_pkg::CH_CR, hrt_pkg::CH_LF);
                add_line_end();
                repeat ($urandom_range(0, 5))
                begin
                    case ($urandom_range(0, 7))
                        0: req_bytes.push_back(hrt_pkg::CH_CR);
                        1: req_bytes.push_back(hrt_pkg::CH_LF);
                        default: ;
                    endcase
                    add_text($urandom_range(0, 6), hrt_pkg::CH_COLON, hrt_pkg::CH_LF);
                    add_str(":");
                    repeat ($urandom_range(0, 3))
                        add_str(" ");
                    add_text($urandom_range(0, 8), hrt_pkg::CH_CR, hrt_pkg::CH_LF);
                    add_line_end();
                end
                req_bytes.push_back(hrt_pkg::CH_CR);
                req_bytes.push_back(hrt_pkg::CH_LF);
                add_any($urandom_range(0, 16));
                // Some requests are cut off at a random point.
                if (sel < 22)
                begin
                    cut = $urandom_range(1, req_bytes.size());
                    while (req_bytes.size() > cut)
                        void'(req_bytes.pop_back());
                end
            end
            send_request();
        end
        s_tvalid <= 1'b0;

        // Sample the checker away from the rising edge so its count is settled.
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Drove %0d bytes in %0d requests: methods, truncations, held CRs, noise,",
                 items_sent, requests_sent);
        $display("a header count overflow and a long output stall; %0d results checked.",
                 result_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/hrt_pkg.sv
hw/rtl/hrt_front.sv
hw/rtl/hrt_queue.sv
hw/rtl/hrt_back.sv
hw/rtl/http_request_tokenizer.sv
verif/http_tokenizer_checker.sv
verif/tb_top.sv
